[src/tcb_pkg.sv]
// shared constants for the text cell buffer engine
package tcb_pkg;

    localparam int DEF_SCREEN_COLUMNS = 80;
    localparam int DEF_SCREEN_ROWS    = 25;

    localparam int CELL_W = 16;
    localparam int CMD_W  = 3;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FILL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SCROLL = 3'd4;

    localparam logic [7:0]        BLANK_CHAR = 8'h20;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    typedef logic [CELL_W-1:0] t_cell;

    function automatic t_cell make_cell(input logic [7:0] ch, input logic [7:0] attr);
        return {attr, ch};
    endfunction

endpackage

[src/text_cell_buffer_engine.sv]
// character cell screen store with clear, put, fill, read and scroll commands
//
// Put and commands that touch nothing finish in the accepting cycle; an on-screen
// read passes through a read state, since the cell memory read is registered.
// Clear and fill then sweep their cells, writing one cell per cycle. Scroll moves
// rows row+1 to bottom_row-1 up by one row through the memory's read and write
// ports, passes a drain state when rows are copied, and then blanks the last row.
// After reset a clearing pass writes every cell, during which no input is taken.
// The result of each command sits in an output register; a new command is taken
// only while that register is empty or being read in the same cycle.
module text_cell_buffer_engine #(
    parameter int SCREEN_COLUMNS = tcb_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = tcb_pkg::DEF_SCREEN_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [tcb_pkg::CMD_W-1:0]  i_command,
    input  logic signed [7:0]          i_row,
    input  logic signed [7:0]          i_col,
    input  logic [7:0]                 i_height,
    input  logic [7:0]                 i_width,
    input  logic [6:0]                 i_bottom_row,
    input  logic [7:0]                 i_char_code,
    input  logic [7:0]                 i_attr,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [tcb_pkg::CELL_W-1:0] o_read_data,
    output logic                       o_in_range
);

    localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int ROW_W      = $clog2(SCREEN_ROWS + 1);
    localparam int COL_W      = $clog2(SCREEN_COLUMNS + 1);

    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(SCREEN_COLUMNS);
    localparam logic signed [9:0] ROWS_S = 10'(SCREEN_ROWS);
    localparam logic signed [9:0] COLS_S = 10'(SCREEN_COLUMNS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_SCR   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    tcb_pkg::t_cell r_mem [CELL_COUNT];

    logic [2:0]          r_state, n_state;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [COL_W-1:0]    r_c0, n_c0;
    logic [ROW_W-1:0]    r_rlast, n_rlast;
    logic [COL_W-1:0]    r_clast, n_clast;
    tcb_pkg::t_cell      r_wdata, n_wdata;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [ADDR_W-1:0]   r_end, n_end;
    logic [ROW_W-1:0]    r_blank_row, n_blank_row;
    logic                r_wpend;
    logic [ADDR_W-1:0]   r_waddr;
    tcb_pkg::t_cell      r_rd_data;
    logic                r_out_valid;
    tcb_pkg::t_cell      r_read_data;
    logic                r_in_range;

    logic                acc;
    logic                out_take;
    logic signed [9:0]   s_row, s_col, s_bot, s_r1, s_c1, s_r0, s_c0, s_r1c, s_c1c;
    logic                on_scr;
    logic                fill_empty;
    logic                scroll_ok;
    logic [ADDR_W-1:0]   in_addr;
    logic [ADDR_W-1:0]   sweep_addr;
    logic                put_we;
    logic                sweep_we;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    tcb_pkg::t_cell      mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                load_out;
    tcb_pkg::t_cell      load_data;
    logic                load_hit;

    assign o_in_stall  = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign acc         = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_in_range  = r_in_range;

    assign s_row  = {{2{i_row[7]}}, i_row};
    assign s_col  = {{2{i_col[7]}}, i_col};
    assign s_bot  = {3'b000, i_bottom_row};
    assign s_r1   = s_row + signed'({2'b00, i_height});
    assign s_c1   = s_col + signed'({2'b00, i_width});
    assign s_r0   = (s_row < 0) ? 10'sd0 : s_row;
    assign s_c0   = (s_col < 0) ? 10'sd0 : s_col;
    assign s_r1c  = (s_r1 > ROWS_S) ? ROWS_S : s_r1;
    assign s_c1c  = (s_c1 > COLS_S) ? COLS_S : s_c1;
    assign fill_empty = (s_r1c <= s_r0) || (s_c1c <= s_c0);
    assign on_scr = (s_row >= 0) && (s_row < ROWS_S) && (s_col >= 0) && (s_col < COLS_S);
    assign scroll_ok = (s_row >= 0) && (s_row < s_bot) && (s_bot <= ROWS_S);

    assign in_addr = ADDR_W'(i_row[ROW_W-1:0]) * COLS_A + ADDR_W'(i_col[COL_W-1:0]);
    assign sweep_addr = ADDR_W'(r_row) * COLS_A + ADDR_W'(r_col);

    assign put_we   = acc && (i_command == tcb_pkg::CMD_PUT) && on_scr;
    assign sweep_we = (r_state == ST_SWEEP);
    assign mem_we   = put_we || sweep_we || r_wpend;

    always_comb begin
        priority if (r_wpend) begin
            mem_waddr = r_waddr;
            mem_wdata = r_rd_data;
        end else if (sweep_we) begin
            mem_waddr = sweep_addr;
            mem_wdata = r_wdata;
        end else begin
            mem_waddr = in_addr;
            mem_wdata = tcb_pkg::make_cell(i_char_code, i_attr);
        end
    end

    assign mem_raddr = (r_state == ST_SCR) ? (r_addr + COLS_A) : in_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_c0        = r_c0;
        n_rlast     = r_rlast;
        n_clast     = r_clast;
        n_wdata     = r_wdata;
        n_addr      = r_addr;
        n_end       = r_end;
        n_blank_row = r_blank_row;
        load_out    = 1'b0;
        load_data   = '0;
        load_hit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    load_out = 1'b1;
                    unique case (i_command)
                        tcb_pkg::CMD_CLEAR: begin
                            n_state = ST_SWEEP;
                            n_row   = '0;
                            n_col   = '0;
                            n_c0    = '0;
                            n_rlast = ROW_W'(SCREEN_ROWS - 1);
                            n_clast = COL_W'(SCREEN_COLUMNS - 1);
                            n_wdata = tcb_pkg::make_cell(tcb_pkg::BLANK_CHAR, i_attr);
                        end
                        tcb_pkg::CMD_PUT: begin
                            load_hit = on_scr;
                        end
                        tcb_pkg::CMD_FILL: begin
                            if (!fill_empty) begin
                                n_state = ST_SWEEP;
                                n_row   = s_r0[ROW_W-1:0];
                                n_col   = s_c0[COL_W-1:0];
                                n_c0    = s_c0[COL_W-1:0];
                                n_rlast = ROW_W'(s_r1c - 10'sd1);
                                n_clast = COL_W'(s_c1c - 10'sd1);
                                n_wdata = tcb_pkg::make_cell(i_char_code, i_attr);
                            end
                        end
                        tcb_pkg::CMD_READ: begin
                            if (on_scr) begin
                                load_out = 1'b0;
                                n_state  = ST_READ;
                            end
                        end
                        tcb_pkg::CMD_SCROLL: begin
                            if (scroll_ok) begin
                                n_wdata     = tcb_pkg::make_cell(tcb_pkg::BLANK_CHAR, i_attr);
                                n_blank_row = ROW_W'(s_bot - 10'sd1);
                                n_addr      = in_addr - ADDR_W'(i_col[COL_W-1:0]);
                                n_end       = ADDR_W'(s_bot - 10'sd1) * COLS_A
                                              - ADDR_W'(1);
                                n_row       = ROW_W'(s_bot - 10'sd1);
                                n_col       = '0;
                                n_c0        = '0;
                                n_rlast     = ROW_W'(s_bot - 10'sd1);
                                n_clast     = COL_W'(SCREEN_COLUMNS - 1);
                                if (s_row == s_bot - 10'sd1) begin
                                    n_state = ST_SWEEP;
                                end else begin
                                    n_addr  = ADDR_W'(i_row[ROW_W-1:0]) * COLS_A;
                                    n_state = ST_SCR;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (r_col == r_clast) begin
                    if (r_row == r_rlast) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                        n_col = r_c0;
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            ST_READ: begin
                load_out  = 1'b1;
                load_data = r_rd_data;
                load_hit  = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_SCR: begin
                n_addr = r_addr + ADDR_W'(1);
                if (r_addr == r_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_SWEEP;
                n_row   = r_blank_row;
                n_col   = '0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_row       <= '0;
            r_col       <= '0;
            r_c0        <= '0;
            r_rlast     <= ROW_W'(SCREEN_ROWS - 1);
            r_clast     <= COL_W'(SCREEN_COLUMNS - 1);
            r_wdata     <= tcb_pkg::RESET_CELL;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_c0    <= n_c0;
            r_rlast <= n_rlast;
            r_clast <= n_clast;
            r_wdata <= n_wdata;
            r_wpend <= (r_state == ST_SCR);
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_end       <= n_end;
        r_blank_row <= n_blank_row;
        r_waddr     <= r_addr;
        if (load_out) begin
            r_read_data <= load_data;
            r_in_range  <= load_hit;
        end
    end

    // one write source per cycle
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({put_we, sweep_we, r_wpend}))
        else $error("cell memory write sources overlap");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> (r_state == ST_IDLE))
        else $error("transfer taken while busy");

    // output slot must be free when a read result lands
    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !r_out_valid)
        else $error("read result would overwrite pending result");

    a_pend_from_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> ((r_state == ST_SCR) || (r_state == ST_DRAIN)))
        else $error("copy write outside scroll");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> ((r_row <= r_rlast) && (r_col <= r_clast)))
        else $error("sweep ran past its rectangle");

endmodule

[bench/tb.sv]
// self-checking testbench for the text cell buffer engine
`timescale 1ns / 1ps

module tb;

    localparam int COLS  = tcb_pkg::DEF_SCREEN_COLUMNS;
    localparam int ROWS  = tcb_pkg::DEF_SCREEN_ROWS;
    localparam int CELLS = COLS * ROWS;

    typedef logic [tcb_pkg::CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_SPARE_LO = 3'd5;
    localparam t_cmd CMD_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS    = 1400;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        t_cmd              command;
        logic signed [7:0] row;
        logic signed [7:0] col;
        logic [7:0]        height;
        logic [7:0]        width;
        logic [6:0]        bottom_row;
        logic [7:0]        char_code;
        logic [7:0]        attr;
    } t_screen_cmd;

    typedef struct packed {
        tcb_pkg::t_cell read_data;
        logic           in_range;
    } t_cell_reply;

    class t_scoreboard;
        tcb_pkg::t_cell screen [CELLS];
        t_cell_reply    replies_due [$];
        int             errors;

        function new();
            foreach (screen[i]) screen[i] = tcb_pkg::RESET_CELL;
            errors = 0;
        endfunction

        function bit on_screen(int r, int k);
            return r >= 0 && r < ROWS && k >= 0 && k < COLS;
        endfunction

        function void note_command(t_screen_cmd c);
            int             r, k, top, left, stop_r, stop_c, bot;
            t_cell_reply    rep;
            tcb_pkg::t_cell fill_cell, blank;
            top       = int'(c.row);
            left      = int'(c.col);
            bot       = int'(c.bottom_row);
            rep       = '0;
            fill_cell = {c.attr, c.char_code};
            blank     = {c.attr, tcb_pkg::BLANK_CHAR};
            case (c.command)
                tcb_pkg::CMD_CLEAR: begin
                    foreach (screen[i]) screen[i] = blank;
                end
                tcb_pkg::CMD_PUT: begin
                    if (on_screen(top, left)) begin
                        screen[top * COLS + left] = fill_cell;
                        rep.in_range = 1'b1;
                    end
                end
                tcb_pkg::CMD_FILL: begin
                    stop_r = top + int'(c.height);
                    stop_c = left + int'(c.width);
                    if (stop_r > ROWS) stop_r = ROWS;
                    if (stop_c > COLS) stop_c = COLS;
                    for (r = (top < 0) ? 0 : top; r < stop_r; r++)
                        for (k = (left < 0) ? 0 : left; k < stop_c; k++)
                            screen[r * COLS + k] = fill_cell;
                end
                tcb_pkg::CMD_READ: begin
                    if (on_screen(top, left)) begin
                        rep.read_data = screen[top * COLS + left];
                        rep.in_range  = 1'b1;
                    end
                end
                tcb_pkg::CMD_SCROLL: begin
                    if (top >= 0 && top < bot && bot <= ROWS) begin
                        for (r = top; r < bot - 1; r++)
                            for (k = 0; k < COLS; k++)
                                screen[r * COLS + k] = screen[(r + 1) * COLS + k];
                        for (k = 0; k < COLS; k++)
                            screen[(bot - 1) * COLS + k] = blank;
                    end
                end
                default: ;
            endcase
            replies_due.push_back(rep);
        endfunction

        function void check_result(tcb_pkg::t_cell data, logic hit);
            t_cell_reply want;
            if (replies_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, %s %h in_range %b",
                         $time, "actual read_data", data, hit);
                return;
            end
            want = replies_due.pop_front();
            if (data !== want.read_data) begin
                errors++;
                $display("%0t: read_data mismatch, expected %h, actual %h",
                         $time, want.read_data, data);
            end
            if (hit !== want.in_range) begin
                errors++;
                $display("%0t: in_range mismatch, expected %b, actual %b",
                         $time, want.in_range, hit);
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    t_cmd                       i_command;
    logic signed [7:0]          i_row;
    logic signed [7:0]          i_col;
    logic [7:0]                 i_height;
    logic [7:0]                 i_width;
    logic [6:0]                 i_bottom_row;
    logic [7:0]                 i_char_code;
    logic [7:0]                 i_attr;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [tcb_pkg::CELL_W-1:0] o_read_data;
    logic                       o_in_range;

    t_scoreboard board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    text_cell_buffer_engine DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_height     (i_height),
        .i_width      (i_width),
        .i_bottom_row (i_bottom_row),
        .i_char_code  (i_char_code),
        .i_attr       (i_attr),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_in_range   (o_in_range)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (holds_served < hold_requests) begin
            holds_served++;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_read_data, o_in_range);
    end

    function automatic t_screen_cmd mk(t_cmd command, int row, int col,
                                       int height, int width, int bottom_row,
                                       int char_code, int attr);
        t_screen_cmd c;
        c.command    = command;
        c.row        = 8'(row);
        c.col        = 8'(col);
        c.height     = 8'(height);
        c.width      = 8'(width);
        c.bottom_row = 7'(bottom_row);
        c.char_code  = 8'(char_code);
        c.attr       = 8'(attr);
        return c;
    endfunction

    function automatic logic signed [7:0] near_row();
        if ($urandom_range(9) != 0) return 8'($urandom_range(ROWS - 1));
        return 8'($urandom);
    endfunction

    function automatic logic signed [7:0] near_col();
        if ($urandom_range(9) != 0) return 8'($urandom_range(COLS - 1));
        return 8'($urandom);
    endfunction

    function automatic t_screen_cmd random_command();
        t_screen_cmd c;
        int          pick, top, bot;
        c = mk(tcb_pkg::CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
        pick = $urandom_range(99);
        if (pick < 2) begin
            c.command = tcb_pkg::CMD_CLEAR;
        end else if (pick < 30) begin
            c.command = tcb_pkg::CMD_PUT;
            c.row     = near_row();
            c.col     = near_col();
        end else if (pick < 60) begin
            c.command = tcb_pkg::CMD_READ;
            c.row     = near_row();
            c.col     = near_col();
        end else if (pick < 80) begin
            c.command = tcb_pkg::CMD_FILL;
            if ($urandom_range(9) != 0) begin
                c.row    = near_row();
                c.col    = near_col();
                c.height = 8'($urandom_range(4));
                c.width  = 8'($urandom_range(16));
            end
        end else if (pick < 92) begin
            c.command = tcb_pkg::CMD_SCROLL;
            if ($urandom_range(9) != 0) begin
                top = $urandom_range(ROWS - 1);
                bot = top + 1 + $urandom_range(2);
                if (bot > ROWS) bot = ROWS;
                c.row        = 8'(top);
                c.bottom_row = 7'(bot);
            end else if ($urandom_range(1) != 0) begin
                top          = $urandom_range(ROWS - 1);
                c.row        = 8'(top);
                c.bottom_row = 7'($urandom_range(ROWS, top + 1));
            end
        end else if (pick < 96) begin
            c.command = t_cmd'($urandom);
        end else begin
            c.command = t_cmd'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        end
        return c;
    endfunction

    task automatic send_cmd(input t_screen_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= c.command;
        i_row        <= c.row;
        i_col        <= c.col;
        i_height     <= c.height;
        i_width      <= c.width;
        i_bottom_row <= c.bottom_row;
        i_char_code  <= c.char_code;
        i_attr       <= c.attr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_command(c);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int phase;
        int n;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = tcb_pkg::CMD_CLEAR;
        i_row        = '0;
        i_col        = '0;
        i_height     = '0;
        i_width      = '0;
        i_bottom_row = '0;
        i_char_code  = '0;
        i_attr       = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_cmd(mk(tcb_pkg::CMD_READ,     0,    0,   0,   0,   0, 'h00, 'h00));
        send_cmd(mk(tcb_pkg::CMD_READ,    24,   79,   0,   0,   0, 'h00, 'h00));
        send_cmd(mk(tcb_pkg::CMD_CLEAR,    0,    0,   0,   0,   0, 'h00, 'h00));
        send_cmd(mk(tcb_pkg::CMD_PUT,      0,    0,   0,   0,   0, 'h00, 'hff));
        send_cmd(mk(tcb_pkg::CMD_PUT,     24,   79,   0,   0,   0, 'hff, 'h00));
        send_cmd(mk(tcb_pkg::CMD_PUT,   -128,  127,   0,   0,   0, 'h41, 'h1f));
        send_cmd(mk(tcb_pkg::CMD_PUT,     25,    0,   0,   0,   0, 'h42, 'h1f));
        send_cmd(mk(tcb_pkg::CMD_PUT,      0,   80,   0,   0,   0, 'h43, 'h1f));
        send_cmd(mk(tcb_pkg::CMD_READ,     0,    0,   0,   0,   0, 'h00, 'h00));
        send_cmd(mk(tcb_pkg::CMD_READ,    24,   79,   0,   0,   0, 'h00, 'h00));
        send_cmd(mk(tcb_pkg::CMD_READ,   127, -128,   0,   0,   0, 'h00, 'h00));
        send_cmd(mk(tcb_pkg::CMD_READ,    -1,   -1,   0,   0,   0, 'h00, 'h00));
        // negative starts clip to the top left corner
        send_cmd(mk(tcb_pkg::CMD_FILL,    -3,   -5,   6,  10,   0, 'h2a, 'h3c));
        send_cmd(mk(tcb_pkg::CMD_FILL,    10,   10,   0,  10,   0, 'h2b, 'h3c));
        send_cmd(mk(tcb_pkg::CMD_FILL,    10,   10,   5,   0,   0, 'h2c, 'h3c));
        send_cmd(mk(tcb_pkg::CMD_FILL,    20,   70, 255, 255,   0, 'h2d, 'h5a));
        send_cmd(mk(tcb_pkg::CMD_FILL,   127,  127, 255, 255, 127, 'hff, 'hff));
        send_cmd(mk(tcb_pkg::CMD_READ,     0,    0,   0,   0,   0, 'h00, 'h00));
        send_cmd(mk(tcb_pkg::CMD_SCROLL,   0,    0,   0,   0,  25, 'h00, 'h4e));
        send_cmd(mk(tcb_pkg::CMD_SCROLL,   3,    0,   0,   0,   4, 'h00, 'h71));
        send_cmd(mk(tcb_pkg::CMD_SCROLL,  -1,    0,   0,   0,   5, 'h00, 'h11));
        send_cmd(mk(tcb_pkg::CMD_SCROLL,   5,    0,   0,   0,   5, 'h00, 'h22));
        send_cmd(mk(tcb_pkg::CMD_SCROLL,   0,    0,   0,   0,  26, 'h00, 'h33));
        send_cmd(mk(tcb_pkg::CMD_SCROLL,   0,    0,   0,   0, 127, 'h00, 'h44));
        send_cmd(mk(CMD_SPARE_LO,          1,    1,   9,   9,   9, 'h55, 'h66));
        send_cmd(mk(CMD_SPARE_HI,          2,    2,   9,   9,   9, 'h77, 'h88));
        send_cmd(mk(tcb_pkg::CMD_CLEAR,    0,    0,   0,   0,   0, 'h00, 'hff));

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
                // long receiver hold-off so the block backs up into its input
                if (phase == 0 && n == 100) hold_requests++;
                send_cmd(random_command());
            end
            if (phase == 1) wait_drained();
        end

        wait_drained();
        repeat (50) @(negedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
src/tcb_pkg.sv
src/text_cell_buffer_engine.sv
bench/tb.sv
